>>> sv/rbws_pkg.sv
// Package for the replica bid window selector.
// Holds the request types, the controller/datapath command and status
// structs and the datapath operation codes. No dependencies.
package rbws_pkg;

  localparam int unsigned TickW = 48;
  localparam int unsigned TgtW  = 10;
  localparam int unsigned DurW  = 32;
  localparam int unsigned RcW   = 4;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_REPLICA_COUNT     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRANSFER_DURATION = 2'd1;

  localparam logic [RcW-1:0]  RcReset  = 4'd3;
  localparam logic [DurW-1:0] DurReset = 32'd10000;

  typedef struct packed {
    logic [TickW-1:0] offer_start;
    logic [TickW-1:0] bid_limit;
    logic [TickW-1:0] ack_estimate;
    logic [TgtW-1:0]  bidder_target;
    logic [TgtW-1:0]  bidder_qdepth;
    logic             last_bid;
  } bid_t;

  typedef struct packed {
    logic [TgtW-1:0]  chosen_target;
    logic [TickW-1:0] window_begin;
    logic [TickW-1:0] window_end;
    logic [TgtW-1:0]  peak_qdepth;
    logic             found;
    logic             last_result;
  } res_t;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_START,
    OP_DCOPY,
    OP_DSHIFT,
    OP_SPAN,
    OP_SCAN,
    OP_ROT,
    OP_GLOAD,
    OP_GROW,
    OP_SORT_ACK,
    OP_QLOAD,
    OP_MAXQ,
    OP_EMIT,
    OP_FAIL
  } op_e;

  typedef struct packed {
    op_e  op;
    logic cnt_clr;
    logic cnt_inc;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic nb_lt_r;
    logic cnt_last;
    logic cnt_eq_rm1;
    logic cnt_eq_base;
    logic grow_stop;
    logic grow_short;
    logic grow_long;
  } sts_t;

endpackage

>>> sv/rbws_ctrl.sv
// Controller of the replica bid window selector: the sequencing state machine.
// Depends on rbws_pkg for the command and status structs.
module rbws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rbws_pkg::sts_t     sts_i,
  output rbws_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_SORT   = 4'd2;
  localparam logic [3:0] ST_DCOPY  = 4'd3;
  localparam logic [3:0] ST_DSHIFT = 4'd4;
  localparam logic [3:0] ST_SPAN   = 4'd5;
  localparam logic [3:0] ST_SCAN   = 4'd6;
  localparam logic [3:0] ST_ROT    = 4'd7;
  localparam logic [3:0] ST_GROW   = 4'd8;
  localparam logic [3:0] ST_ASORT  = 4'd9;
  localparam logic [3:0] ST_QLOAD  = 4'd10;
  localparam logic [3:0] ST_MAXQ   = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;
  localparam logic [3:0] ST_FAIL   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       in_acc, out_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT) || (state_q == ST_FAIL);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o.op      = rbws_pkg::OP_NONE;
    cmd_o.cnt_clr = 1'b0;
    cmd_o.cnt_inc = 1'b0;
    cmd_o.adv     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.op = rbws_pkg::OP_LOAD;
          if (in_last_i) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.cnt_clr = 1'b1;
        state_d = sts_i.nb_lt_r ? ST_FAIL : ST_SORT;
      end
      ST_SORT: begin
        cmd_o.op = rbws_pkg::OP_SORT_START;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = ST_DCOPY;
      end
      ST_DCOPY: begin
        cmd_o.op = rbws_pkg::OP_DCOPY;
        cmd_o.cnt_clr = 1'b1;
        state_d = ST_DSHIFT;
      end
      ST_DSHIFT: begin
        if (sts_i.cnt_eq_rm1) begin
          state_d = ST_SPAN;
        end else begin
          cmd_o.op = rbws_pkg::OP_DSHIFT;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_SPAN: begin
        cmd_o.op = rbws_pkg::OP_SPAN;
        cmd_o.cnt_clr = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = rbws_pkg::OP_SCAN;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (sts_i.cnt_eq_base) begin
          cmd_o.op = rbws_pkg::OP_GLOAD;
          state_d = ST_GROW;
        end else begin
          cmd_o.op = rbws_pkg::OP_ROT;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_GROW: begin
        cmd_o.op = rbws_pkg::OP_GROW;
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.grow_stop) begin
          if (sts_i.grow_short) state_d = ST_FAIL;
          else if (sts_i.grow_long) state_d = ST_ASORT;
          else state_d = ST_QLOAD;
        end
      end
      ST_ASORT: begin
        cmd_o.op = rbws_pkg::OP_SORT_ACK;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = ST_QLOAD;
      end
      ST_QLOAD: begin
        cmd_o.op = rbws_pkg::OP_QLOAD;
        cmd_o.cnt_clr = 1'b1;
        state_d = ST_MAXQ;
      end
      ST_MAXQ: begin
        cmd_o.op = rbws_pkg::OP_MAXQ;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_eq_rm1) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.op = rbws_pkg::OP_EMIT;
        if (out_acc) begin
          cmd_o.adv = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.cnt_eq_rm1) state_d = ST_IDLE;
        end
      end
      ST_FAIL: begin
        cmd_o.op = rbws_pkg::OP_FAIL;
        if (out_acc) begin
          cmd_o.adv = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rbws_dp.sv
// Datapath of the replica bid window selector: bid store, sort network pass,
// span scan, window growth and result register. Depends on rbws_pkg.
module rbws_dp #(
  parameter int unsigned MAX_BIDS   = 16,
  parameter int unsigned MAX_ACCEPT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbws_pkg::DurW-1:0]     cfg_data_i,
  input  rbws_pkg::bid_t                bid_i,
  input  rbws_pkg::cmd_t                cmd_i,
  output rbws_pkg::sts_t                sts_o,
  output rbws_pkg::res_t                res_o
);

  localparam int unsigned IW = $clog2(MAX_BIDS);
  // Count width; always at least five bits so the replica count fits.
  localparam int unsigned KW = $clog2(MAX_BIDS + MAX_ACCEPT + 16);
  localparam int unsigned TW = rbws_pkg::TickW;
  localparam int unsigned GW = rbws_pkg::TgtW;

  logic [rbws_pkg::RcW-1:0]  rc_q;
  logic [rbws_pkg::DurW-1:0] dur_q;

  logic [TW-1:0] st_q [MAX_BIDS];
  logic [TW-1:0] lm_q [MAX_BIDS];
  logic [TW-1:0] ak_q [MAX_BIDS];
  logic [GW-1:0] tg_q [MAX_BIDS];
  logic [GW-1:0] qd_q [MAX_BIDS];
  logic [TW-1:0] d_q  [MAX_BIDS];
  logic [TW-1:0] gl_q [MAX_BIDS];
  logic [TW-1:0] sp_q [MAX_BIDS];
  logic [GW-1:0] qc_q [MAX_BIDS];
  logic [MAX_BIDS-1:0] spv_q;

  logic [KW-1:0] nb_q, cnt_q, base_q, gn_q, avail_q;
  logic [TW:0]   best_q;
  logic [TW-1:0] wstart_q, wlim_q, wend_q;
  logic [GW-1:0] maxq_q;

  logic [KW-1:0] r_eff, sort_lim;
  logic [TW-1:0] key [MAX_BIDS];
  logic [MAX_BIDS-1:0] swap;
  logic [TW:0]   slack, wend_sum;
  logic          sort_op, finish;

  // Effective replica count: zero counts as one, clamped at MAX_ACCEPT.
  always_comb begin
    if (rc_q == '0) r_eff = KW'(1);
    else if (KW'(rc_q) > KW'(MAX_ACCEPT)) r_eff = KW'(MAX_ACCEPT);
    else r_eff = KW'(rc_q);
  end

  // Odd-even transposition pass; swaps only on strict greater, so stable.
  assign sort_op  = (cmd_i.op == rbws_pkg::OP_SORT_START) ||
                    (cmd_i.op == rbws_pkg::OP_SORT_ACK);
  assign sort_lim = (cmd_i.op == rbws_pkg::OP_SORT_ACK) ? gn_q : nb_q;
  always_comb begin
    for (int i = 0; i < MAX_BIDS; i++) begin
      key[i] = (cmd_i.op == rbws_pkg::OP_SORT_ACK) ? ak_q[i] : st_q[i];
    end
    swap = '0;
    for (int i = 0; i < MAX_BIDS - 1; i++) begin
      swap[i] = sort_op && (1'(i) == cnt_q[0]) && ((KW'(i) + KW'(1)) < sort_lim) &&
                (key[i] > key[i+1]);
    end
  end

  // Window growth test on the head of the shifted copies.
  assign slack = {1'b0, wstart_q} + (TW+1)'(dur_q);
  always_comb begin
    sts_o.grow_stop = (gn_q == avail_q) || (d_q[0] > wlim_q) ||
                      ((gn_q >= r_eff) && ({1'b0, d_q[0]} > slack));
  end
  assign sts_o.grow_short  = gn_q < r_eff;
  assign sts_o.grow_long   = gn_q > r_eff;
  assign sts_o.nb_lt_r     = nb_q < r_eff;
  assign sts_o.cnt_last    = cnt_q == KW'(MAX_BIDS - 1);
  assign sts_o.cnt_eq_rm1  = cnt_q == (r_eff - KW'(1));
  assign sts_o.cnt_eq_base = cnt_q == base_q;

  assign wend_sum = slack;
  assign finish   = cmd_i.adv && ((cmd_i.op == rbws_pkg::OP_FAIL) || sts_o.cnt_eq_rm1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= rbws_pkg::RcReset;
      dur_q <= rbws_pkg::DurReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rbws_pkg::CFG_REPLICA_COUNT) rc_q <= cfg_data_i[rbws_pkg::RcW-1:0];
      if (cfg_index_i == rbws_pkg::CFG_TRANSFER_DURATION) dur_q <= cfg_data_i;
    end
  end

  // Control counters: bid count and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.op == rbws_pkg::OP_LOAD && nb_q < KW'(MAX_BIDS)) nb_q <= nb_q + KW'(1);
      else if (finish) nb_q <= '0;
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + KW'(1);
    end
  end

  // Bid store and working copies.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rbws_pkg::OP_LOAD: begin
        if (nb_q < KW'(MAX_BIDS)) begin
          st_q[nb_q[IW-1:0]] <= bid_i.offer_start;
          lm_q[nb_q[IW-1:0]] <= bid_i.bid_limit;
          ak_q[nb_q[IW-1:0]] <= bid_i.ack_estimate;
          tg_q[nb_q[IW-1:0]] <= bid_i.bidder_target;
          qd_q[nb_q[IW-1:0]] <= bid_i.bidder_qdepth;
        end
      end
      rbws_pkg::OP_SORT_START, rbws_pkg::OP_SORT_ACK: begin
        for (int i = 0; i < MAX_BIDS - 1; i++) begin
          if (swap[i]) begin
            st_q[i] <= st_q[i+1]; st_q[i+1] <= st_q[i];
            lm_q[i] <= lm_q[i+1]; lm_q[i+1] <= lm_q[i];
            ak_q[i] <= ak_q[i+1]; ak_q[i+1] <= ak_q[i];
            tg_q[i] <= tg_q[i+1]; tg_q[i+1] <= tg_q[i];
            qd_q[i] <= qd_q[i+1]; qd_q[i+1] <= qd_q[i];
          end
        end
      end
      rbws_pkg::OP_DCOPY: begin
        for (int i = 0; i < MAX_BIDS; i++) d_q[i] <= st_q[i];
      end
      rbws_pkg::OP_DSHIFT: begin
        for (int i = 0; i < MAX_BIDS - 1; i++) d_q[i] <= d_q[i+1];
      end
      rbws_pkg::OP_SPAN: begin
        // Span of each run of r bids, valid where the run fits the store.
        for (int i = 0; i < MAX_BIDS; i++) begin
          sp_q[i]  <= d_q[i] - st_q[i];
          spv_q[i] <= (KW'(i) + r_eff - KW'(1)) < nb_q;
        end
        best_q <= '1;
        base_q <= '0;
      end
      rbws_pkg::OP_SCAN: begin
        if (spv_q[0] && ({1'b0, sp_q[0]} < best_q)) begin
          best_q <= {1'b0, sp_q[0]};
          base_q <= cnt_q;
        end
        for (int i = 0; i < MAX_BIDS - 1; i++) begin
          sp_q[i]  <= sp_q[i+1];
          spv_q[i] <= spv_q[i+1];
        end
        spv_q[MAX_BIDS-1] <= 1'b0;
      end
      rbws_pkg::OP_ROT: begin
        // Rotate the store so the chosen base sits at the head.
        for (int i = 0; i < MAX_BIDS; i++) begin
          st_q[i] <= st_q[(i+1) % MAX_BIDS];
          lm_q[i] <= lm_q[(i+1) % MAX_BIDS];
          ak_q[i] <= ak_q[(i+1) % MAX_BIDS];
          tg_q[i] <= tg_q[(i+1) % MAX_BIDS];
          qd_q[i] <= qd_q[(i+1) % MAX_BIDS];
        end
      end
      rbws_pkg::OP_GLOAD: begin
        for (int i = 0; i < MAX_BIDS; i++) begin
          d_q[i]  <= st_q[i];
          gl_q[i] <= lm_q[i];
        end
        wstart_q <= st_q[0];
        wlim_q   <= lm_q[0];
        gn_q     <= '0;
        avail_q  <= nb_q - base_q;
      end
      rbws_pkg::OP_GROW: begin
        if (sts_o.grow_stop) begin
          // Write the chosen start back to every member of the set.
          for (int i = 0; i < MAX_BIDS; i++) begin
            if (KW'(i) < gn_q) st_q[i] <= wstart_q;
          end
        end else begin
          if (d_q[0] > wstart_q) wstart_q <= d_q[0];
          if (gl_q[0] < wlim_q) wlim_q <= gl_q[0];
          gn_q <= gn_q + KW'(1);
          for (int i = 0; i < MAX_BIDS - 1; i++) begin
            d_q[i]  <= d_q[i+1];
            gl_q[i] <= gl_q[i+1];
          end
        end
      end
      rbws_pkg::OP_QLOAD: begin
        for (int i = 0; i < MAX_BIDS; i++) qc_q[i] <= qd_q[i];
        maxq_q <= '0;
        wend_q <= wend_sum[TW] ? '1 : wend_sum[TW-1:0];
      end
      rbws_pkg::OP_MAXQ: begin
        if (qc_q[0] > maxq_q) maxq_q <= qc_q[0];
        for (int i = 0; i < MAX_BIDS - 1; i++) qc_q[i] <= qc_q[i+1];
      end
      rbws_pkg::OP_EMIT: begin
        if (cmd_i.adv) begin
          for (int i = 0; i < MAX_BIDS - 1; i++) tg_q[i] <= tg_q[i+1];
        end
      end
      default: ;
    endcase
  end

  // Result payload; on the failure request all fields are zero but last_result, which is set.
  always_comb begin
    if (cmd_i.op == rbws_pkg::OP_EMIT) begin
      res_o.chosen_target = tg_q[0];
      res_o.window_begin  = wstart_q;
      res_o.window_end    = wend_q;
      res_o.peak_qdepth   = maxq_q;
      res_o.found         = 1'b1;
      res_o.last_result   = sts_o.cnt_eq_rm1;
    end else begin
      res_o.chosen_target = '0;
      res_o.window_begin  = '0;
      res_o.window_end    = '0;
      res_o.peak_qdepth   = '0;
      res_o.found         = 1'b0;
      res_o.last_result   = 1'b1;
    end
  end

  // The bid count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) nb_q <= KW'(MAX_BIDS))
    else $error("bid count beyond store depth");
  // Growth never runs past the bids that follow the base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rbws_pkg::OP_GROW |-> gn_q <= avail_q)
    else $error("window growth beyond stored bids");
  // Emission stays within the replica count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rbws_pkg::OP_EMIT |-> cnt_q < r_eff)
    else $error("emit index beyond replica count");
  // A finished run leaves the bid count at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) finish |=> nb_q == '0)
    else $error("bid count not cleared after a run");

endmodule

>>> sv/replica_bid_window_selector_top.sv
// Top level of the replica bid window selector.
// Joins rbws_ctrl and rbws_dp; uses rbws_pkg for the request types.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    rbws_pkg::bid_t
//  out      output     out_valid/out_stall  rbws_pkg::res_t
//  cfg      input      cfg_valid/cfg_ready  index (2 bits), data (32 bits)
//
// A bid without last_bid is taken while the block is idle. A final bid starts selection,
// which sorts by offer start, scans the spans of runs of r bids, rotates the chosen base
// to the head, grows the window, sorts the set by ack estimate when it is larger than r
// (the effective replica count) and finds the peak queue depth; the results then leave
// in turn as out_stall allows. Too few bids give the failure result instead.
// Reset empties the bid count and restores the register defaults. Output stalls hold
// the result; input is stalled until the last result leaves.
module replica_bid_window_selector_top #(
  parameter int unsigned MAX_BIDS   = 16,
  parameter int unsigned MAX_ACCEPT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rbws_pkg::bid_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rbws_pkg::res_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbws_pkg::DurW-1:0]     cfg_data_i
);

  rbws_pkg::cmd_t cmd;
  rbws_pkg::sts_t sts;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  rbws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_bid),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbws_dp #(
    .MAX_BIDS   (MAX_BIDS),
    .MAX_ACCEPT (MAX_ACCEPT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bid_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_data_o)
  );

endmodule
